// File: design/rbsi_pkg.sv
// shared types and constants for the ray box slab intersect core
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_AXES        = 3;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic zero_dir;
        logic in_slab;
    } axis_flags_t;

endpackage

// File: design/ray_box_slab_intersect_core.sv
// ray against axis-aligned box, slab method, pipelined top level
// path from start to done: prep register, divider pipeline, then the merge order, narrow and result stages
// throughput: one ray per cycle, busy stays low, set by the one-bit-per-stage dividers
// results show on done for one cycle; the receiver cannot stall the pipeline
// reset clears all valid bits and the six box corner registers to zero
module ray_box_slab_intersect_core #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic                           cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data,
    input  logic signed [COORD_WIDTH-1:0]  origin_x,
    input  logic signed [COORD_WIDTH-1:0]  origin_y,
    input  logic signed [COORD_WIDTH-1:0]  origin_z,
    input  logic signed [COORD_WIDTH-1:0]  dir_x,
    input  logic signed [COORD_WIDTH-1:0]  dir_y,
    input  logic signed [COORD_WIDTH-1:0]  dir_z,
    output logic                           hit,
    output logic [COORD_WIDTH-2:0]         t_near,
    output logic [COORD_WIDTH-2:0]         t_far
);
    import rbsi_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int DIV_LAT = CW + 2;

    logic signed [CW-1:0] box_lo_reg [NUM_AXES];
    logic signed [CW-1:0] box_hi_reg [NUM_AXES];
    logic signed [CW-1:0] org [NUM_AXES];
    logic signed [CW-1:0] dir [NUM_AXES];

    logic                 p_valid;
    logic [CW-1:0]        p_lo_mag  [NUM_AXES];
    logic [CW-1:0]        p_hi_mag  [NUM_AXES];
    logic                 p_lo_neg  [NUM_AXES];
    logic                 p_hi_neg  [NUM_AXES];
    logic [CW-1:0]        p_den_mag [NUM_AXES];
    axis_flags_t          p_flags   [NUM_AXES];

    logic                 lo_valid [NUM_AXES];
    logic                 hi_valid [NUM_AXES];
    logic signed [CW-1:0] t_lo [NUM_AXES];
    logic signed [CW-1:0] t_hi [NUM_AXES];

    axis_flags_t          flags_dly_reg [DIV_LAT][NUM_AXES];

    // corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                box_lo_reg[k] <= '0;
                box_hi_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                CFG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                CFG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                CFG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                CFG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                CFG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    rbsi_prep #(.CW(CW)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .box_lo    (box_lo_reg),
        .box_hi    (box_hi_reg),
        .org       (org),
        .dir       (dir),
        .out_valid (p_valid),
        .lo_mag    (p_lo_mag),
        .hi_mag    (p_hi_mag),
        .lo_neg    (p_lo_neg),
        .hi_neg    (p_hi_neg),
        .den_mag   (p_den_mag),
        .flags     (p_flags)
    );

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_axis
        rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_lo (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (p_valid),
            .num       (p_lo_mag[k]),
            .den       (p_den_mag[k]),
            .neg       (p_lo_neg[k]),
            .out_valid (lo_valid[k]),
            .quo       (t_lo[k])
        );

        rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_hi (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (p_valid),
            .num       (p_hi_mag[k]),
            .den       (p_den_mag[k]),
            .neg       (p_hi_neg[k]),
            .out_valid (hi_valid[k]),
            .quo       (t_hi[k])
        );
    end

    // axis flags ride alongside the dividers
    always_ff @(posedge clk)
    begin
        flags_dly_reg[0] <= p_flags;
        for (int s = 1; s < DIV_LAT; s++)
        begin
            flags_dly_reg[s] <= flags_dly_reg[s-1];
        end
    end

    rbsi_merge #(.CW(CW)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lo_valid[0] && hi_valid[0]),
        .t_lo      (t_lo),
        .t_hi      (t_hi),
        .flags     (flags_dly_reg[DIV_LAT-1]),
        .out_valid (done),
        .hit       (hit),
        .t_near    (t_near),
        .t_far     (t_far)
    );

endmodule

// File: design/rbsi_prep.sv
// input stage: slab offsets, magnitudes, signs, zero direction and in-slab flags
module rbsi_prep #(
    parameter int CW = rbsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  box_lo [rbsi_pkg::NUM_AXES],
    input  logic signed [CW-1:0]  box_hi [rbsi_pkg::NUM_AXES],
    input  logic signed [CW-1:0]  org    [rbsi_pkg::NUM_AXES],
    input  logic signed [CW-1:0]  dir    [rbsi_pkg::NUM_AXES],
    output logic                  out_valid,
    output logic [CW-1:0]         lo_mag [rbsi_pkg::NUM_AXES],
    output logic [CW-1:0]         hi_mag [rbsi_pkg::NUM_AXES],
    output logic                  lo_neg [rbsi_pkg::NUM_AXES],
    output logic                  hi_neg [rbsi_pkg::NUM_AXES],
    output logic [CW-1:0]         den_mag [rbsi_pkg::NUM_AXES],
    output rbsi_pkg::axis_flags_t flags [rbsi_pkg::NUM_AXES]
);
    import rbsi_pkg::*;

    logic                  valid_reg;
    logic [CW-1:0]         lo_mag_reg  [NUM_AXES];
    logic [CW-1:0]         hi_mag_reg  [NUM_AXES];
    logic                  lo_neg_reg  [NUM_AXES];
    logic                  hi_neg_reg  [NUM_AXES];
    logic [CW-1:0]         den_mag_reg [NUM_AXES];
    axis_flags_t           flags_reg   [NUM_AXES];

    logic [CW-1:0]         lo_mag_next  [NUM_AXES];
    logic [CW-1:0]         hi_mag_next  [NUM_AXES];
    logic                  lo_neg_next  [NUM_AXES];
    logic                  hi_neg_next  [NUM_AXES];
    logic [CW-1:0]         den_mag_next [NUM_AXES];
    axis_flags_t           flags_next   [NUM_AXES];

    always_comb
    begin
        logic signed [CW:0] dlo;
        logic signed [CW:0] dhi;
        logic signed [CW:0] dd;
        logic signed [CW:0] alo;
        logic signed [CW:0] ahi;
        logic signed [CW:0] ad;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            dlo = {box_lo[k][CW-1], box_lo[k]} - {org[k][CW-1], org[k]};
            dhi = {box_hi[k][CW-1], box_hi[k]} - {org[k][CW-1], org[k]};
            dd  = {dir[k][CW-1], dir[k]};
            alo = dlo[CW] ? -dlo : dlo;
            ahi = dhi[CW] ? -dhi : dhi;
            ad  = dd[CW] ? -dd : dd;
            lo_mag_next[k]  = alo[CW-1:0];
            hi_mag_next[k]  = ahi[CW-1:0];
            den_mag_next[k] = ad[CW-1:0];
            lo_neg_next[k]  = dlo[CW] ^ dir[k][CW-1];
            hi_neg_next[k]  = dhi[CW] ^ dir[k][CW-1];
            flags_next[k].zero_dir = (dir[k] == '0);
            flags_next[k].in_slab  = (box_lo[k] <= org[k]) && (org[k] <= box_hi[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_mag_reg  <= lo_mag_next;
        hi_mag_reg  <= hi_mag_next;
        lo_neg_reg  <= lo_neg_next;
        hi_neg_reg  <= hi_neg_next;
        den_mag_reg <= den_mag_next;
        flags_reg   <= flags_next;
    end

    assign out_valid = valid_reg;
    assign lo_mag    = lo_mag_reg;
    assign hi_mag    = hi_mag_reg;
    assign lo_neg    = lo_neg_reg;
    assign hi_neg    = hi_neg_reg;
    assign den_mag   = den_mag_reg;
    assign flags     = flags_reg;

endmodule

// File: design/rbsi_div.sv
// pipelined restoring divider, one quotient bit per stage, floor and saturate
module rbsi_div #(
    parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FB = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [CW-1:0]        num,
    input  logic [CW-1:0]        den,
    input  logic                 neg,
    output logic                 out_valid,
    output logic signed [CW-1:0] quo
);
    import rbsi_pkg::*;

    localparam int NW = CW + FB;
    localparam int EW = 2 * CW + FB;
    localparam logic [CW-1:0] TLIM = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};

    logic          v_reg   [CW+1];
    logic [NW-1:0] p_reg   [CW+1];
    logic [CW-1:0] q_reg   [CW+1];
    logic [CW-1:0] d_reg   [CW+1];
    logic          ovf_reg [CW+1];
    logic          neg_reg [CW+1];

    logic                 out_valid_reg;
    logic signed [CW-1:0] quo_reg;
    logic signed [CW-1:0] quo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0]   <= {num, {FB{1'b0}}};
        q_reg[0]   <= '0;
        d_reg[0]   <= den;
        neg_reg[0] <= neg;
        ovf_reg[0] <= {{CW{1'b0}}, num, {FB{1'b0}}} >= {{FB{1'b0}}, den, {CW{1'b0}}};
    end

    for (genvar j = 1; j <= CW; j++)
    begin : g_stage
        localparam int BIT = CW - j;
        logic [EW-1:0] dsh;
        logic [EW-1:0] pe;
        logic [EW-1:0] diff;
        logic          ge;

        assign dsh  = EW'(d_reg[j-1]) << BIT;
        assign pe   = EW'(p_reg[j-1]);
        assign ge   = pe >= dsh;
        assign diff = pe - dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            p_reg[j]   <= ge ? diff[NW-1:0] : p_reg[j-1];
            q_reg[j]   <= q_reg[j-1] | (CW'(ge) << BIT);
            d_reg[j]   <= d_reg[j-1];
            ovf_reg[j] <= ovf_reg[j-1];
            neg_reg[j] <= neg_reg[j-1];
        end
    end

    always_comb
    begin
        logic          sat;
        logic          rnz;
        logic [CW-1:0] m;
        logic [CW-1:0] mm;
        sat = ovf_reg[CW] || q_reg[CW][CW-1];
        rnz = |p_reg[CW];
        m   = sat ? TLIM : q_reg[CW];
        mm  = m + CW'(rnz && !sat);
        if (neg_reg[CW])
        begin
            quo_next = -$signed(mm);
        end
        else
        begin
            quo_next = sat ? $signed(TMAX) : $signed(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;

endmodule

// File: design/rbsi_merge.sv
// slab ordering, interval narrowing and hit decision
module rbsi_merge #(
    parameter int CW = rbsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  t_lo [rbsi_pkg::NUM_AXES],
    input  logic signed [CW-1:0]  t_hi [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::axis_flags_t flags [rbsi_pkg::NUM_AXES],
    output logic                  out_valid,
    output logic                  hit,
    output logic [CW-2:0]         t_near,
    output logic [CW-2:0]         t_far
);
    import rbsi_pkg::*;

    localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};

    // order stage
    logic                 a_valid_reg;
    logic signed [CW-1:0] a_mn_reg   [NUM_AXES];
    logic signed [CW-1:0] a_mx_reg   [NUM_AXES];
    logic                 a_skip_reg [NUM_AXES];
    logic                 a_bad_reg  [NUM_AXES];

    // narrow stage
    logic                 b_valid_reg;
    logic signed [CW-1:0] b_t0_reg;
    logic signed [CW-1:0] b_t1_reg;
    logic                 b_miss_reg;
    logic signed [CW-1:0] b_t0_next;
    logic signed [CW-1:0] b_t1_next;
    logic                 b_miss_next;

    // result stage
    logic                 c_valid_reg;
    logic                 c_hit_reg;
    logic [CW-2:0]        c_near_reg;
    logic [CW-2:0]        c_far_reg;
    logic                 c_hit_next;

    always_comb
    begin
        b_t0_next   = '0;
        b_t1_next   = TMAX;
        b_miss_next = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (!a_skip_reg[k])
            begin
                if (a_mn_reg[k] > b_t0_next)
                begin
                    b_t0_next = a_mn_reg[k];
                end
                if (a_mx_reg[k] < b_t1_next)
                begin
                    b_t1_next = a_mx_reg[k];
                end
            end
            b_miss_next = b_miss_next | a_bad_reg[k];
        end
    end

    assign c_hit_next = b_valid_reg && !b_miss_reg && (b_t0_reg <= b_t1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            a_mn_reg[k]   <= (t_lo[k] > t_hi[k]) ? t_hi[k] : t_lo[k];
            a_mx_reg[k]   <= (t_lo[k] > t_hi[k]) ? t_lo[k] : t_hi[k];
            a_skip_reg[k] <= flags[k].zero_dir;
            a_bad_reg[k]  <= flags[k].zero_dir && !flags[k].in_slab;
        end
        b_t0_reg   <= b_t0_next;
        b_t1_reg   <= b_t1_next;
        b_miss_reg <= b_miss_next;
        c_hit_reg  <= c_hit_next;
        c_near_reg <= c_hit_next ? b_t0_reg[CW-2:0] : '0;
        c_far_reg  <= c_hit_next ? b_t1_reg[CW-2:0] : '0;
    end

    assign out_valid = c_valid_reg;
    assign hit       = c_hit_reg;
    assign t_near    = c_near_reg;
    assign t_far     = c_far_reg;

endmodule

// File: design/rbsi_checker.sv
// port level checks for the ray box slab intersect core
module rbsi_checker #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic                   hit,
    input logic [COORD_WIDTH-2:0] t_near,
    input logic [COORD_WIDTH-2:0] t_far
);
    import rbsi_pkg::*;

    localparam int LAT = COORD_WIDTH + 6;

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("done without an accepted word");

    a_hit_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit outside a result word");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (t_near == '0 && t_far == '0))
        else $error("miss with nonzero distances");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (t_near <= t_far))
        else $error("near distance beyond far distance");

endmodule

bind ray_box_slab_intersect_core rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .hit    (hit),
    .t_near (t_near),
    .t_far  (t_far)
);
